// ===== rtl/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and codes for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Status codes reported with every result item
  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_HEADER  = 2'd1,
    ST_ERROR   = 2'd2,
    ST_DONE    = 2'd3
  } status_t;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_CR1     = 3'd0,
    PH_LF1     = 3'd1,
    PH_DIGITS  = 3'd2,
    PH_LF2     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERROR   = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/ctd_in_if.sv =====
// ----------------------------------------------------------------------------
// ctd_in_if
// Input byte channel: valid/ready handshake with one raw byte per item.
// ----------------------------------------------------------------------------
interface ctd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/ctd_out_if.sv =====
// ----------------------------------------------------------------------------
// ctd_out_if
// Result channel: valid/ready handshake with one decoded result per item.
// ----------------------------------------------------------------------------
interface ctd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic              out_valid;
  ctd_pkg::status_t  status;

  modport source (output valid, output out_byte, output out_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input status,
                  output ready);
endinterface

// ===== rtl/ctd_out_buf.sv =====
// ----------------------------------------------------------------------------
// ctd_out_buf
// Two-entry result buffer: head register plus skid register.
// ----------------------------------------------------------------------------
module ctd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ctd_pkg::result_t  push_data,
  ctd_out_if.source         out_ch
);

  logic [1:0]       count_r, count_nxt;
  ctd_pkg::result_t head_r, head_nxt;
  ctd_pkg::result_t skid_r, skid_nxt;
  logic             push, pop;

  assign push_ready = (count_r != 2'd2);
  assign push       = push_valid && push_ready;
  assign pop        = out_ch.valid && out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    skid_nxt  = skid_r;
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_nxt = push_data;
        end else begin
          skid_nxt = push_data;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        head_nxt  = skid_r;
        count_nxt = count_r - 2'd1;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_nxt = push_data;
        end else begin
          head_nxt = skid_r;
          skid_nxt = push_data;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid     = (count_r != 2'd0);
  assign out_ch.out_byte  = head_r.out_byte;
  assign out_ch.out_valid = head_r.out_valid;
  assign out_ch.status    = head_r.status;

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Byte-serial decoder for a chunked-encoded body stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one raw byte of the chunked body per item (valid/ready).
//   out_ch : exactly one result item per input item, in order: the byte
//            (when out_valid is set), out_valid and a 2-bit status
//            (payload, header, error, done).
//   Each header is CR LF, up to MAX_SIZE_DIGITS hex digits, CR LF; the
//   digits give the count of payload bytes that follow. A zero size ends
//   the body (done). Any other header byte is an error. Error and done are
//   sticky; later bytes are consumed and answered with the same status.
//   Output: the result of an item is written to the result buffer when it is
//   accepted. Throughput: one item per cycle while the buffer has room, set
//   by the single decode step on the phase, size and digit registers.
//   Stall: a two-entry result buffer lets one more item be taken while a
//   result waits; in_ch.ready drops only when both entries are full.
//   Reset (rst_n low, synchronous): phase returns to "expect first CR",
//   counters clear and the result buffer empties.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
  parameter int MAX_SIZE_DIGITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  ctd_in_if.sink    in_ch,
  ctd_out_if.source out_ch
);

  localparam int SIZE_W  = 4 * MAX_SIZE_DIGITS;
  localparam int COUNT_W = $clog2(MAX_SIZE_DIGITS + 1);
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SIZE_DIGITS);

  // Hex digit decode: bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = {1'b0, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = {1'b0, 4'(c - 8'h61 + 8'd10)};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  ctd_pkg::phase_t    phase_r, phase_nxt;
  logic [SIZE_W-1:0]  left_r, left_nxt;
  logic [COUNT_W-1:0] digits_r, digits_nxt;

  logic             accept;
  logic             buf_ready;
  logic [4:0]       hv;
  logic [SIZE_W-1:0] left_dec;
  ctd_pkg::result_t result;

  assign in_ch.ready = buf_ready;
  assign accept      = in_ch.valid && buf_ready;
  assign hv          = hex_value(in_ch.in_byte);
  assign left_dec    = (left_r != '0) ? left_r - SIZE_W'(1) : left_r;

  // Next-state decode for one byte
  always_comb begin
    phase_nxt  = phase_r;
    left_nxt   = left_r;
    digits_nxt = digits_r;
    unique case (phase_r)
      ctd_pkg::PH_CR1: begin
        phase_nxt = (in_ch.in_byte == ctd_pkg::CH_CR) ? ctd_pkg::PH_LF1
                                                      : ctd_pkg::PH_ERROR;
      end
      ctd_pkg::PH_LF1: begin
        if (in_ch.in_byte == ctd_pkg::CH_LF) begin
          phase_nxt  = ctd_pkg::PH_DIGITS;
          left_nxt   = '0;
          digits_nxt = '0;
        end else begin
          phase_nxt = ctd_pkg::PH_ERROR;
        end
      end
      ctd_pkg::PH_DIGITS: begin
        if (in_ch.in_byte == ctd_pkg::CH_CR) begin
          phase_nxt = ctd_pkg::PH_LF2;
        end else if (hv[4] || digits_r >= MAX_CNT) begin
          phase_nxt = ctd_pkg::PH_ERROR;
        end else begin
          left_nxt   = (left_r << 4) | SIZE_W'(hv[3:0]);
          digits_nxt = digits_r + COUNT_W'(1);
        end
      end
      ctd_pkg::PH_LF2: begin
        if (in_ch.in_byte != ctd_pkg::CH_LF) begin
          phase_nxt = ctd_pkg::PH_ERROR;
        end else if (left_r == '0) begin
          phase_nxt = ctd_pkg::PH_DONE;
        end else begin
          phase_nxt = ctd_pkg::PH_PAYLOAD;
        end
      end
      ctd_pkg::PH_PAYLOAD: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt  = ctd_pkg::PH_CR1;
          digits_nxt = '0;
        end
      end
      ctd_pkg::PH_DONE: begin
      end
      ctd_pkg::PH_ERROR: begin
      end
      default: begin
        phase_nxt = ctd_pkg::PH_ERROR;
      end
    endcase
  end

  // Result for this byte; error and done override
  always_comb begin
    result.out_byte  = 8'h00;
    result.out_valid = 1'b0;
    result.status    = ctd_pkg::ST_HEADER;
    if (phase_r == ctd_pkg::PH_PAYLOAD) begin
      result.out_byte  = in_ch.in_byte;
      result.out_valid = 1'b1;
      result.status    = ctd_pkg::ST_PAYLOAD;
    end
    if (phase_nxt == ctd_pkg::PH_ERROR) begin
      result.status = ctd_pkg::ST_ERROR;
    end else if (phase_nxt == ctd_pkg::PH_DONE) begin
      result.status = ctd_pkg::ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ctd_pkg::PH_CR1;
      left_r   <= '0;
      digits_r <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      left_r   <= left_nxt;
      digits_r <= digits_nxt;
    end
  end

  ctd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_ch.valid),
    .push_ready (buf_ready),
    .push_data  (result),
    .out_ch     (out_ch)
  );

endmodule
